FILE: hdl/qte_pkg.sv
// Shared types, constants and angle table for the quaternion to Euler converter.
`timescale 1ns / 1ps
package qte_pkg;

  localparam int CORDIC_STAGES       = 16;  // vectoring iterations, 8..24
  localparam int ANGLE_FRACTION_BITS = 7;   // output fraction bits, 4..12
  localparam int TABLE_FRAC          = 24;  // fraction bits of the angle table
  localparam int ROUND_SH            = TABLE_FRAC - ANGLE_FRACTION_BITS;

  localparam int OP_W    = 35;  // sums of products, Q.28, with headroom
  localparam int S_W     = 30;  // clamped asin argument, +-2^28
  localparam int ROOT_W  = 58;  // square-root remainder and root accumulator
  localparam int ROOT_N  = 29;  // root digits for a 57-bit radicand
  localparam int VEC_W   = 37;  // CORDIC x/y, covers gain and pre-rotation
  localparam int ANG_W   = 34;  // degrees * 2^24 accumulator
  localparam int IDX_W   = 5;   // CORDIC stage index
  localparam int SHR_W   = 6;   // root digit position

  localparam logic signed [ANG_W-1:0] DEG90 = ANG_W'(64'sd1509949440);

  typedef logic signed [OP_W-1:0]  op_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic signed [ANG_W-1:0] ang_t;

  // vector in flight through a CORDIC cell
  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic zero;
  } cvec_t;

  // operands that ride along the square-root chain
  typedef struct packed {
    op_t              roll_x;
    op_t              roll_y;
    op_t              yaw_x;
    op_t              yaw_y;
    logic signed [S_W-1:0] s;
    logic             flag;
  } side_t;

  // atan(2^-i) in degrees * 2^24, rounded to nearest
  function automatic ang_t atan_deg(input logic [IDX_W-1:0] i);
    ang_t a;
    case (i)
      5'd0:  a = ANG_W'(64'sd754974720);
      5'd1:  a = ANG_W'(64'sd445687602);
      5'd2:  a = ANG_W'(64'sd235489088);
      5'd3:  a = ANG_W'(64'sd119537938);
      5'd4:  a = ANG_W'(64'sd60000934);
      5'd5:  a = ANG_W'(64'sd30029717);
      5'd6:  a = ANG_W'(64'sd15018523);
      5'd7:  a = ANG_W'(64'sd7509720);
      5'd8:  a = ANG_W'(64'sd3754917);
      5'd9:  a = ANG_W'(64'sd1877466);
      5'd10: a = ANG_W'(64'sd938734);
      5'd11: a = ANG_W'(64'sd469367);
      5'd12: a = ANG_W'(64'sd234684);
      5'd13: a = ANG_W'(64'sd117342);
      5'd14: a = ANG_W'(64'sd58671);
      5'd15: a = ANG_W'(64'sd29335);
      5'd16: a = ANG_W'(64'sd14668);
      5'd17: a = ANG_W'(64'sd7334);
      5'd18: a = ANG_W'(64'sd3667);
      5'd19: a = ANG_W'(64'sd1833);
      5'd20: a = ANG_W'(64'sd917);
      5'd21: a = ANG_W'(64'sd458);
      5'd22: a = ANG_W'(64'sd229);
      5'd23: a = ANG_W'(64'sd115);
      default: a = '0;
    endcase
    return a;
  endfunction

  // quadrant pre-rotation into the right half plane; (0,0) is marked
  function automatic cvec_t pre_rotate(input op_t x, input op_t y);
    cvec_t v;
    v.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      if (y >= 0) begin
        v.x = VEC_W'(y);
        v.y = -VEC_W'(x);
        v.z = DEG90;
      end else begin
        v.x = -VEC_W'(y);
        v.y = VEC_W'(x);
        v.z = -DEG90;
      end
    end else begin
      v.x = VEC_W'(x);
      v.y = VEC_W'(y);
      v.z = '0;
    end
    return v;
  endfunction

endpackage

FILE: hdl/qte_sqrt_cell.sv
// One digit of the integer square root, registered, with side operands passed along.
`timescale 1ns / 1ps
module qte_sqrt_cell
  import qte_pkg::*;
(
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [SHR_W-1:0]  pos_i,   // digit weight is 2^pos_i
  input  logic [ROOT_W-1:0] rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  side_t             side_i,
  output logic [ROOT_W-1:0] rem_o,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic [ROOT_W-1:0] bit_w, trial;
  logic [ROOT_W-1:0] rem_d, root_d;

  always_comb begin
    bit_w = ROOT_W'(1) << pos_i;
    trial = root_i + bit_w;
    if (rem_i >= trial) begin
      rem_d  = rem_i - trial;
      root_d = (root_i >> 1) + bit_w;
    end else begin
      rem_d  = rem_i;
      root_d = root_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      root_o <= root_d;
      side_o <= side_i;
    end
  end

endmodule

FILE: hdl/qte_cordic_cell.sv
// One CORDIC vectoring iteration, registered.
`timescale 1ns / 1ps
module qte_cordic_cell
  import qte_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IDX_W-1:0] stage_i,
  input  cvec_t            vec_i,
  output cvec_t            vec_o
);

  vec_t  dx, dy;
  ang_t  a;
  cvec_t vec_d;

  always_comb begin
    dx = vec_i.x >>> stage_i;
    dy = vec_i.y >>> stage_i;
    a  = atan_deg(stage_i);
    vec_d.zero = vec_i.zero;
    if (!vec_i.y[VEC_W-1]) begin
      vec_d.x = vec_i.x + dy;
      vec_d.y = vec_i.y - dx;
      vec_d.z = vec_i.z + a;
    end else begin
      vec_d.x = vec_i.x - dy;
      vec_d.y = vec_i.y + dx;
      vec_d.z = vec_i.z - a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_o <= vec_d;
    end
  end

endmodule

FILE: hdl/quaternion_to_euler.sv
// Top level: quaternion in, ZYX Euler angles out, fully pipelined.
`timescale 1ns / 1ps
// Converts one Q1.14 quaternion per request into roll, pitch and yaw in
// 1/128 degree. Input requests arrive on the s_axis group, results leave on
// the m_axis group; a request is taken when tvalid and tready are both high.
// Throughput: one request per cycle while the pipe is not stalled. Every stage
// is a register, so a new request can enter while earlier ones are still in the pipe.
// Stages from acceptance to m_axis_tvalid_o:
//   1 product stage (ten 16x16 multipliers), 1 sum/clamp stage,
//   1 squaring stage for s^2, 29 square-root digit cells,
//   1 quadrant pre-rotation stage, 16 CORDIC cells (three vectors side by
//   side), then the rounding/saturating output register.
// The square-root and CORDIC cell rows set the latency; each cell hands its
// data on whenever the pipe enable is high.
// Stall: the whole pipe advances on one enable, high when the output
// register is empty or being drained. While the receiver holds tready low
// with a result waiting, nothing moves and s_axis_tready_o is low.
// Reset: rst_ni clears all valid bits; no results are pending afterwards.
// pitch_clamped (tuser) is set when |asin argument| exceeded one.
module quaternion_to_euler
  import qte_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,   // quat_w[15:0], quat_x, quat_y, quat_z
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,   // roll[15:0], pitch[30:16], yaw[46:31], 0
  output logic        m_axis_tuser_o    // pitch_clamped
);

  localparam int NSTAGE = 3 + ROOT_N + 1 + CORDIC_STAGES;

  logic en;
  logic [NSTAGE-1:0] vld_q;
  logic m_valid_q;

  assign en              = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = m_valid_q;

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      m_valid_q <= 1'b0;
    end else if (en) begin
      vld_q     <= {vld_q[NSTAGE-2:0], s_axis_tvalid_i};
      m_valid_q <= vld_q[NSTAGE-1];
    end
  end

  // stage 1: products
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, yz_q, wx_q, xy_q, wz_q, xz_q, wy_q;

  assign qw = s_axis_tdata_i[15:0];
  assign qx = s_axis_tdata_i[31:16];
  assign qy = s_axis_tdata_i[47:32];
  assign qz = s_axis_tdata_i[63:48];

  always_ff @(posedge clk_i) begin
    if (en) begin
      ww_q <= 32'(qw) * 32'(qw);
      xx_q <= 32'(qx) * 32'(qx);
      yy_q <= 32'(qy) * 32'(qy);
      zz_q <= 32'(qz) * 32'(qz);
      yz_q <= 32'(qy) * 32'(qz);
      wx_q <= 32'(qw) * 32'(qx);
      xy_q <= 32'(qx) * 32'(qy);
      wz_q <= 32'(qw) * 32'(qz);
      xz_q <= 32'(qx) * 32'(qz);
      wy_q <= 32'(qw) * 32'(qy);
    end
  end

  // stage 2: sums, asin argument clamp
  localparam op_t ONE_Q28 = OP_W'(64'sd268435456);
  op_t   s_raw;
  side_t side_d, side_q;

  always_comb begin
    side_d.roll_y = (OP_W'(yz_q) + OP_W'(wx_q)) <<< 1;
    side_d.roll_x = OP_W'(ww_q) - OP_W'(xx_q) - OP_W'(yy_q) + OP_W'(zz_q);
    side_d.yaw_y  = (OP_W'(xy_q) + OP_W'(wz_q)) <<< 1;
    side_d.yaw_x  = OP_W'(ww_q) + OP_W'(xx_q) - OP_W'(yy_q) - OP_W'(zz_q);
    s_raw         = (OP_W'(wy_q) - OP_W'(xz_q)) <<< 1;
    if (s_raw > ONE_Q28) begin
      side_d.s    = S_W'(ONE_Q28);
      side_d.flag = 1'b1;
    end else if (s_raw < -ONE_Q28) begin
      side_d.s    = -S_W'(ONE_Q28);
      side_d.flag = 1'b1;
    end else begin
      side_d.s    = S_W'(s_raw);
      side_d.flag = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q <= side_d;
    end
  end

  // stage 3: s^2 on the magnitude
  logic [S_W-2:0]     s_mag;
  logic [2*S_W-3:0]   sq_q;
  side_t              side_sq_q;

  assign s_mag = side_q.s[S_W-1] ? (S_W-1)'(-side_q.s) : side_q.s[S_W-2:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q      <= (2*S_W-2)'(s_mag) * (2*S_W-2)'(s_mag);
      side_sq_q <= side_q;
    end
  end

  // square-root cell row: c = floor(sqrt(2^56 - s^2))
  logic [ROOT_W-1:0] rem_c  [0:ROOT_N];
  logic [ROOT_W-1:0] root_c [0:ROOT_N];
  side_t             side_c [0:ROOT_N];

  assign rem_c[0]  = (ROOT_W'(1) << (2 * (ROOT_N - 1))) - ROOT_W'(sq_q);
  assign root_c[0] = '0;
  assign side_c[0] = side_sq_q;

  for (genvar k = 0; k < ROOT_N; k++) begin : g_root
    qte_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .pos_i  (SHR_W'(2 * (ROOT_N - 1 - k))),
      .rem_i  (rem_c[k]),
      .root_i (root_c[k]),
      .side_i (side_c[k]),
      .rem_o  (rem_c[k+1]),
      .root_o (root_c[k+1]),
      .side_o (side_c[k+1])
    );
  end

  // pre-rotation
  cvec_t roll_v [0:CORDIC_STAGES];
  cvec_t pit_v  [0:CORDIC_STAGES];
  cvec_t yaw_v  [0:CORDIC_STAGES];
  logic  flag_v [0:CORDIC_STAGES];

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_v[0] <= pre_rotate(side_c[ROOT_N].roll_x, side_c[ROOT_N].roll_y);
      pit_v[0]  <= pre_rotate(OP_W'(root_c[ROOT_N]), OP_W'(side_c[ROOT_N].s));
      yaw_v[0]  <= pre_rotate(side_c[ROOT_N].yaw_x, side_c[ROOT_N].yaw_y);
      flag_v[0] <= side_c[ROOT_N].flag;
    end
  end

  // CORDIC cell row, three vectors per column
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    qte_cordic_cell u_roll (
      .clk_i(clk_i), .en_i(en), .stage_i(IDX_W'(i)),
      .vec_i(roll_v[i]), .vec_o(roll_v[i+1])
    );
    qte_cordic_cell u_pitch (
      .clk_i(clk_i), .en_i(en), .stage_i(IDX_W'(i)),
      .vec_i(pit_v[i]), .vec_o(pit_v[i+1])
    );
    qte_cordic_cell u_yaw (
      .clk_i(clk_i), .en_i(en), .stage_i(IDX_W'(i)),
      .vec_i(yaw_v[i]), .vec_o(yaw_v[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        flag_v[i+1] <= flag_v[i];
      end
    end
  end

  // round half up, saturate to the field width
  function automatic logic [15:0] to_field(input cvec_t v, input int unsigned w);
    ang_t t, hi, lo;
    hi = (ANG_W'(1) <<< (w - 1)) - ANG_W'(1);
    lo = -hi - ANG_W'(1);
    t  = (v.z + (ANG_W'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    if (v.zero) begin
      t = '0;
    end else if (t > hi) begin
      t = hi;
    end else if (t < lo) begin
      t = lo;
    end
    return t[15:0];
  endfunction

  logic [15:0] roll_f, pitch_f, yaw_f;
  logic [15:0] roll_q, yaw_q;
  logic [14:0] pitch_q;
  logic        clamp_q;

  assign roll_f  = to_field(roll_v[CORDIC_STAGES], 16);
  assign pitch_f = to_field(pit_v[CORDIC_STAGES], 15);
  assign yaw_f   = to_field(yaw_v[CORDIC_STAGES], 16);

  always_ff @(posedge clk_i) begin
    if (en) begin
      roll_q  <= roll_f;
      pitch_q <= pitch_f[14:0];
      yaw_q   <= yaw_f;
      clamp_q <= flag_v[CORDIC_STAGES];
    end
  end

  assign m_axis_tdata_o = {1'b0, yaw_q, pitch_q, roll_q};
  assign m_axis_tuser_o = clamp_q;

  // ---- assertions ----
  a_ready_tracks_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input ready does not follow output drain");

  a_valid_from_pipe : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(vld_q[NSTAGE-1]))
    else $error("result appeared without a request in the last stage");

  a_clamped_pitch_vertical : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      ($signed(pitch_q) >= 15'sd11000 || $signed(pitch_q) <= -15'sd11000))
    else $error("clamped asin argument did not give a vertical pitch");

endmodule
